// ----- rtl/kfpi_pkg.sv -----
// ----------------------------------------------------------------------------
// kfpi_pkg
// shared constants and types for the keyframe position interpolator
// ----------------------------------------------------------------------------
package kfpi_pkg;

    localparam int KEY_DEPTH_DEF   = 64;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int SCAN_WINDOW_DEF = 4;

    localparam int TIME_W   = 32;
    localparam int POS_W    = 32;
    localparam int COUNT_W  = 7;
    localparam int INDEX_W  = 6;
    localparam int WEIGHT_W = 17;
    localparam int STATUS_W = 2;

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 128;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PAST  = 2'd2;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

// ----- rtl/kfpi_divider.sv -----
// ----------------------------------------------------------------------------
// kfpi_divider
// restoring divider, one quotient bit per cycle, quotient saturated to one
// ----------------------------------------------------------------------------
module kfpi_divider
    import kfpi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [TIME_W-1:0]     numer,
    input  logic [TIME_W-1:0]     denom,
    output div_ctl_t              ctl,
    output logic [FRAC_BITS:0]    quot
);

    localparam int NB = TIME_W + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [NB-1:0]     num_reg, num_next;
    logic [TIME_W:0]   rem_reg, rem_next;
    logic [TIME_W-1:0] den_reg;
    logic [NB-1:0]     q_reg, q_next;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg, done_reg;
    logic [TIME_W:0]   trial;

    always_comb
    begin
        trial    = {rem_reg[TIME_W-1:0], num_reg[NB-1]};
        num_next = {num_reg[NB-2:0], 1'b0};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = trial - {1'b0, den_reg};
            q_next   = {q_reg[NB-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial;
            q_next   = {q_reg[NB-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NB);
                num_reg  <= {numer, {FRAC_BITS{1'b0}}};
                den_reg  <= denom;
                rem_reg  <= '0;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                num_reg <= num_next;
                rem_reg <= rem_next;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quot = (q_reg > NB'(ONE)) ? ONE : q_reg[FRAC_BITS:0];

endmodule

// ----- rtl/keyframe_position_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// keyframe_position_interpolator_unit
// keyframe table with binary search, scan and linear position blend
// ----------------------------------------------------------------------------
// s_axis carries load and query items; kind in tuser selects which. a load
// writes one keyframe into the time and position memories and gives no
// result. a query searches the time memory, one synchronous read per step,
// for the last key below the query time, divides for the weight with a
// serial divider, then blends the two keys one axis at a time. one result
// leaves on m_axis per query. one item is in work at a time;
// s_axis_tready is low while a query runs or while the result waits in the
// output register for m_axis_tready. key_count is written on
// cfg_valid/cfg_ready; the user must write it only while idle, which the
// block itself does not enforce. reset clears control state and
// key_count; the memories hold nothing until loaded.
// ----------------------------------------------------------------------------
module keyframe_position_interpolator_unit
    import kfpi_pkg::*;
#(
    parameter int KEY_DEPTH   = KEY_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SCAN_WINDOW = SCAN_WINDOW_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // key_index, key_time, key_x, key_y, key_z, query_time
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // base_index, weight, pos_x, pos_y, pos_z, status, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COUNT_W-1:0]    cfg_data
);

    localparam int AW  = $clog2(KEY_DEPTH);
    localparam int NW  = AW + 1;
    localparam int WMX = (KEY_DEPTH < 64) ? AW : INDEX_W;

    typedef enum logic [3:0] {
        S_IDLE, S_LAST, S_LAST_W, S_BIN, S_BIN_W, S_SCAN, S_SCAN_W,
        S_T0, S_T1, S_DIV, S_DIV_W, S_P0, S_P1, S_MUL, S_OUT
    } state_t;

    logic [TIME_W-1:0] time_mem [KEY_DEPTH];
    logic [POS_W-1:0]  x_mem [KEY_DEPTH];
    logic [POS_W-1:0]  y_mem [KEY_DEPTH];
    logic [POS_W-1:0]  z_mem [KEY_DEPTH];

    state_t            state_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [NW-1:0]     n_reg;
    logic [TIME_W-1:0] q_reg, t0_reg, rd_t_reg;
    logic [POS_W-1:0]  rd_x_reg, rd_y_reg, rd_z_reg;
    logic [POS_W-1:0]  p0x_reg, p0y_reg, p0z_reg;
    logic [AW-1:0]     rd_addr, i0_reg, i1_reg, mid_reg, base_reg;
    logic [NW-1:0]     scan_reg;
    logic [1:0]        axis_reg;
    logic [2:0]        ph_reg;
    logic [FRAC_BITS:0] w_reg;
    logic              div_start;
    div_ctl_t          div_ctl;
    logic [FRAC_BITS:0] div_q;
    logic [TIME_W-1:0] div_num, div_den;
    logic signed [POS_W:0] d_reg;
    logic signed [POS_W+FRAC_BITS+2:0] prod_reg;
    logic [POS_W-1:0]  res_reg [3];
    logic [STATUS_W-1:0] status_reg;
    logic              m_valid_reg;
    logic              load_fire, query_fire;

    logic [INDEX_W-1:0] in_index;
    assign in_index = s_axis_tdata[5:0];

    assign s_axis_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign cfg_ready     = 1'b1;
    assign load_fire  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_LOAD);
    assign query_fire = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_QUERY);

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (load_fire && (32'(in_index) < 32'(KEY_DEPTH)))
        begin
            time_mem[AW'(in_index)] <= s_axis_tdata[37:6];
            x_mem[AW'(in_index)]    <= s_axis_tdata[69:38];
            y_mem[AW'(in_index)]    <= s_axis_tdata[101:70];
            z_mem[AW'(in_index)]    <= s_axis_tdata[133:102];
        end
        rd_t_reg <= time_mem[rd_addr];
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
        rd_z_reg <= z_mem[rd_addr];
    end

    always_comb
    begin
        unique case (state_reg)
            S_LAST:  rd_addr = AW'(n_reg - NW'(1));
            S_BIN:   rd_addr = AW'((NW'(i0_reg) + NW'(i1_reg)) >> 1);
            S_SCAN:  rd_addr = AW'(scan_reg - NW'(1));
            S_T0:    rd_addr = base_reg;
            S_P0:    rd_addr = base_reg;
            S_T1, S_DIV_W, S_P1, S_MUL:
                     rd_addr = AW'(NW'(base_reg) + NW'(1));
            default: rd_addr = base_reg;
        endcase
    end

    assign div_num   = q_reg - t0_reg;
    assign div_den   = rd_t_reg - t0_reg;
    assign div_start = (state_reg == S_DIV);

    kfpi_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_num),
        .denom (div_den),
        .ctl   (div_ctl),
        .quot  (div_q)
    );

    logic [POS_W-1:0] p1_sel, p0_sel;
    always_comb
    begin
        case (axis_reg)
            2'd0:    begin p1_sel = rd_x_reg; p0_sel = p0x_reg; end
            2'd1:    begin p1_sel = rd_y_reg; p0_sel = p0y_reg; end
            default: begin p1_sel = rd_z_reg; p0_sel = p0z_reg; end
        endcase
    end

    // arithmetic shift floors toward minus infinity
    logic signed [POS_W+FRAC_BITS+2:0] prod_sh;
    assign prod_sh = prod_reg >>> FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            status_reg  <= ST_OK;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                count_reg <= cfg_data;
            if (m_valid_reg && m_axis_tready)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (query_fire)
                    begin
                        q_reg <= s_axis_tdata[165:134];
                        n_reg <= (32'(count_reg) > 32'(KEY_DEPTH)) ? NW'(KEY_DEPTH)
                                                                    : NW'(count_reg);
                        base_reg <= '0;
                        w_reg    <= '0;
                        res_reg[0] <= '0; res_reg[1] <= '0; res_reg[2] <= '0;
                        if (count_reg == '0)
                        begin
                            status_reg <= ST_EMPTY;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            status_reg <= ST_OK;
                            state_reg  <= S_LAST;
                        end
                    end
                end
                S_LAST: state_reg <= S_LAST_W;
                S_LAST_W:
                begin
                    i0_reg <= '0;
                    i1_reg <= AW'(n_reg - NW'(1));
                    if (q_reg >= rd_t_reg)
                    begin
                        base_reg   <= AW'(n_reg - NW'(1));
                        status_reg <= ST_PAST;
                        state_reg  <= S_OUT;
                    end
                    else
                        state_reg <= S_BIN;
                end
                S_BIN:
                begin
                    if (32'(i1_reg - i0_reg) > 32'(SCAN_WINDOW))
                    begin
                        mid_reg   <= rd_addr;
                        state_reg <= S_BIN_W;
                    end
                    else
                    begin
                        scan_reg  <= NW'(i1_reg) + NW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_BIN_W:
                begin
                    if (rd_t_reg < q_reg)
                        i0_reg <= mid_reg;
                    else
                        i1_reg <= mid_reg;
                    state_reg <= S_BIN;
                end
                S_SCAN:
                begin
                    if (scan_reg == '0)
                        state_reg <= S_T0;
                    else
                        state_reg <= S_SCAN_W;
                end
                S_SCAN_W:
                begin
                    if (rd_t_reg < q_reg)
                    begin
                        base_reg  <= AW'(scan_reg - NW'(1));
                        state_reg <= S_T0;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg - NW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_T0:
                begin
                    if (NW'(base_reg) >= n_reg - NW'(1))
                    begin
                        status_reg <= ST_PAST;
                        state_reg  <= S_OUT;
                    end
                    else
                        state_reg <= S_T1;
                end
                S_T1:
                begin
                    t0_reg    <= rd_t_reg;
                    p0x_reg   <= rd_x_reg;
                    p0y_reg   <= rd_y_reg;
                    p0z_reg   <= rd_z_reg;
                    state_reg <= S_DIV_W;
                end
                S_DIV_W:
                begin
                    // rd_t_reg now holds t1
                    if (q_reg <= t0_reg || rd_t_reg <= t0_reg)
                    begin
                        w_reg     <= '0;
                        state_reg <= S_P1;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:  state_reg <= S_P0;
                S_P0:
                begin
                    if (div_ctl.done)
                    begin
                        w_reg     <= div_q;
                        state_reg <= S_P1;
                    end
                end
                S_P1:
                begin
                    axis_reg  <= 2'd0;
                    prod_reg  <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // d then product then sum, one axis at a time
                    d_reg    <= $signed({p1_sel[POS_W-1], p1_sel})
                              - $signed({p0_sel[POS_W-1], p0_sel});
                    prod_reg <= d_reg * $signed({1'b0, w_reg});
                    if (ph_reg == 3'd2)
                    begin
                        res_reg[axis_reg] <= POS_W'($signed({p0_sel[POS_W-1], p0_sel})
                                                    + prod_sh);
                        if (axis_reg == 2'd2)
                            state_reg <= S_OUT;
                        else
                            axis_reg <= axis_reg + 2'd1;
                    end
                end
                S_OUT:
                begin
                    if (!m_valid_reg)
                    begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // three-phase counter for the blend sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ph_reg <= '0;
        else if (state_reg != S_MUL)
            ph_reg <= '0;
        else if (ph_reg == 3'd2)
            ph_reg <= '0;
        else
            ph_reg <= ph_reg + 3'd1;
    end

    logic [INDEX_W-1:0] base_out;
    assign base_out = INDEX_W'(base_reg[WMX-1:0]);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, status_reg, res_reg[2], res_reg[1], res_reg[0],
                            WEIGHT_W'(w_reg), base_out};

    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !m_axis_tready |=> m_valid_reg)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (w_reg <= ((FRAC_BITS+1)'(1) << FRAC_BITS)))
        else $error("weight above one");

endmodule

// ----- tb/sv/tb_keyframe_position_interpolator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_position_interpolator_unit
// self-checking testbench for the keyframe position interpolator
// ----------------------------------------------------------------------------
// a queue of load and query items feeds a clocked driver with random gaps; a
// local copy of the key table and key_count predicts every query result at
// input transfer, and a clocked monitor with random stalls compares results
// field by field. key_count is rewritten between phases while idle, with a
// long output hold-off to back up the block.
// ----------------------------------------------------------------------------
module tb_keyframe_position_interpolator_unit;
    import kfpi_pkg::*;

    localparam int DEPTH      = 64;
    localparam int DRAIN_CYC  = 200;
    localparam int WATCH_LIM  = 20000;
    localparam int HOLD_LEN   = 600;

    typedef struct {
        logic                kind;
        logic [INDEX_W-1:0]  idx;
        logic [TIME_W-1:0]   ktime;
        logic [POS_W-1:0]    kx;
        logic [POS_W-1:0]    ky;
        logic [POS_W-1:0]    kz;
        logic [TIME_W-1:0]   qtime;
    } kf_item_t;

    typedef struct {
        logic [INDEX_W-1:0]  base;
        logic [WEIGHT_W-1:0] weight;
        logic [POS_W-1:0]    px;
        logic [POS_W-1:0]    py;
        logic [POS_W-1:0]    pz;
        logic [STATUS_W-1:0] status;
    } kf_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [COUNT_W-1:0]    cfg_data;

    kf_item_t   pending_items[$];
    kf_result_t expected_positions[$];

    // predictor state
    logic [TIME_W-1:0] tbl_t[DEPTH];
    logic [POS_W-1:0]  tbl_x[DEPTH];
    logic [POS_W-1:0]  tbl_y[DEPTH];
    logic [POS_W-1:0]  tbl_z[DEPTH];
    int unsigned       live_count;

    // stimulus planning copy of key times
    logic [TIME_W-1:0] plan_t[DEPTH];
    bit                plan_written[DEPTH];

    int  errors;
    int  results_seen;
    int  idle_cycles;
    bit  burst_mode;
    int  send_gap;
    int  recv_gap;
    int  long_hold;
    bit  hold_done;
    kf_item_t cur_item;

    keyframe_position_interpolator_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [POS_W-1:0] blend_axis(logic [POS_W-1:0] a, logic [POS_W-1:0] b,
                                                    logic [WEIGHT_W-1:0] w);
        longint p0;
        longint d;
        longint prod;
        p0   = longint'($signed(a));
        d    = longint'($signed(b)) - p0;
        prod = d * longint'({1'b0, w});
        return POS_W'(p0 + (prod >>> FRAC_BITS_DEF));
    endfunction

    function automatic int unsigned search_base(int unsigned n, logic [TIME_W-1:0] q);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = n - 1;
        if (q >= tbl_t[n-1])
            return n - 1;
        while (hi - lo > SCAN_WINDOW_DEF)
        begin
            mid = (lo + hi) / 2;
            if (tbl_t[mid] < q)
                lo = mid;
            else
                hi = mid;
        end
        for (int i = hi + 1; i > 0; i--)
            if (tbl_t[i-1] < q)
                return i - 1;
        return 0;
    endfunction

    function automatic kf_result_t interpolate(logic [TIME_W-1:0] q);
        kf_result_t r;
        int unsigned n;
        int unsigned b;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t1;
        logic [63:0] w;
        r = '{default: '0};
        n = (live_count > DEPTH) ? DEPTH : live_count;
        if (n == 0)
        begin
            r.status = ST_EMPTY;
            return r;
        end
        b = search_base(n, q);
        r.base = INDEX_W'(b);
        if (b >= n - 1)
        begin
            r.status = ST_PAST;
            return r;
        end
        t0 = tbl_t[b];
        t1 = tbl_t[b+1];
        if (q <= t0 || t1 <= t0)
            w = 0;
        else
        begin
            w = ({32'd0, q - t0} << FRAC_BITS_DEF) / {32'd0, t1 - t0};
            if (w > (64'd1 << FRAC_BITS_DEF))
                w = 64'd1 << FRAC_BITS_DEF;
        end
        r.weight = WEIGHT_W'(w);
        r.px     = blend_axis(tbl_x[b], tbl_x[b+1], r.weight);
        r.py     = blend_axis(tbl_y[b], tbl_y[b+1], r.weight);
        r.pz     = blend_axis(tbl_z[b], tbl_z[b+1], r.weight);
        r.status = ST_OK;
        return r;
    endfunction

    task automatic apply_item(kf_item_t it);
        if (it.kind == KIND_LOAD)
        begin
            tbl_t[it.idx] = it.ktime;
            tbl_x[it.idx] = it.kx;
            tbl_y[it.idx] = it.ky;
            tbl_z[it.idx] = it.kz;
        end
        else
            expected_positions.push_back(interpolate(it.qtime));
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        logic nv;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= KIND_LOAD;
            send_gap      = 0;
            burst_mode    = 1'b0;
        end
        else
        begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_item(cur_item);
                nv = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    burst_mode = ~burst_mode;
                send_gap = burst_mode ? 0 : $urandom_range(0, 6);
            end
            if (!nv)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_items.size() > 0)
                begin
                    cur_item = pending_items.pop_front();
                    nv = 1'b1;
                    s_axis_tuser <= cur_item.kind;
                    s_axis_tdata <= {2'b00, cur_item.qtime, cur_item.kz, cur_item.ky,
                                     cur_item.kx, cur_item.ktime, cur_item.idx};
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        kf_result_t got;
        kf_result_t exp_r;
        logic nr;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      = 0;
            long_hold     = 0;
            hold_done     = 1'b0;
            results_seen  = 0;
        end
        else
        begin
            nr = m_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.base   = m_axis_tdata[5:0];
                got.weight = m_axis_tdata[22:6];
                got.px     = m_axis_tdata[54:23];
                got.py     = m_axis_tdata[86:55];
                got.pz     = m_axis_tdata[118:87];
                got.status = m_axis_tdata[120:119];
                results_seen++;
                if (expected_positions.size() == 0)
                begin
                    $display("%0t: unexpected result base %0d status %0d", $time,
                             got.base, got.status);
                    errors++;
                end
                else
                begin
                    exp_r = expected_positions.pop_front();
                    if (got.base !== exp_r.base)
                    begin
                        $display("%0t: base_index exp %0d got %0d", $time, exp_r.base, got.base);
                        errors++;
                    end
                    if (got.weight !== exp_r.weight)
                    begin
                        $display("%0t: weight exp %h got %h", $time, exp_r.weight, got.weight);
                        errors++;
                    end
                    if (got.px !== exp_r.px)
                    begin
                        $display("%0t: pos_x exp %h got %h", $time, exp_r.px, got.px);
                        errors++;
                    end
                    if (got.py !== exp_r.py)
                    begin
                        $display("%0t: pos_y exp %h got %h", $time, exp_r.py, got.py);
                        errors++;
                    end
                    if (got.pz !== exp_r.pz)
                    begin
                        $display("%0t: pos_z exp %h got %h", $time, exp_r.pz, got.pz);
                        errors++;
                    end
                    if (got.status !== exp_r.status)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                        errors++;
                    end
                end
                nr = 1'b0;
                recv_gap = burst_mode ? 0 : $urandom_range(0, 6);
                if (results_seen == 60 && !hold_done)
                begin
                    long_hold = HOLD_LEN;
                    hold_done = 1'b1;
                end
            end
            if (!nr)
            begin
                if (long_hold > 0)
                    long_hold--;
                else if (recv_gap > 0)
                    recv_gap--;
                else
                    nr = 1'b1;
            end
            m_axis_tready <= nr;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCH_LIM)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic wait_idle();
        do
        begin
            while (pending_items.size() > 0 || s_axis_tvalid
                   || expected_positions.size() > 0)
                @(posedge clk);
            repeat (DRAIN_CYC) @(posedge clk);
        end
        while (pending_items.size() > 0 || s_axis_tvalid || expected_positions.size() > 0);
    endtask

    task automatic write_key_count(int unsigned n);
        wait_idle();
        cfg_data  <= COUNT_W'(n);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        live_count = (n > DEPTH) ? DEPTH : n;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] pick_pos();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_load(int unsigned k, logic [TIME_W-1:0] t,
                             logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [POS_W-1:0] z);
        kf_item_t it;
        it.kind  = KIND_LOAD;
        it.idx   = INDEX_W'(k);
        it.ktime = t;
        it.kx    = x;
        it.ky    = y;
        it.kz    = z;
        it.qtime = $urandom;
        plan_t[k]       = t;
        plan_written[k] = 1'b1;
        pending_items.push_back(it);
    endtask

    task automatic push_query(logic [TIME_W-1:0] q);
        kf_item_t it;
        it.kind  = KIND_QUERY;
        it.idx   = INDEX_W'($urandom);
        it.ktime = $urandom;
        it.kx    = $urandom;
        it.ky    = $urandom;
        it.kz    = $urandom;
        it.qtime = q;
        pending_items.push_back(it);
    endtask

    function automatic logic [TIME_W-1:0] pick_query(int unsigned n);
        int unsigned k;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return plan_t[k];
            3: return plan_t[k] + 1;
            4: return plan_t[k] - 1;
            5: return $urandom;
            default: return plan_t[k] + $urandom_range(0, 32'h0200_0000);
        endcase
    endfunction

    task automatic random_phase(int unsigned n, int unsigned items);
        int unsigned k;
        logic [TIME_W-1:0] t;
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(0, 9) < 7 || n == 0)
                push_query(pick_query((n == 0) ? 1 : n));
            else
            begin
                k = $urandom_range(0, DEPTH - 1);
                case ($urandom_range(0, 5))
                    0: t = $urandom;
                    1: t = (k > 0) ? plan_t[k-1] : 32'h0;
                    default:
                    begin
                        if (k > 0 && k < DEPTH - 1 && plan_t[k+1] > plan_t[k-1])
                            t = plan_t[k-1] + $urandom_range(0, plan_t[k+1] - plan_t[k-1]);
                        else
                            t = plan_t[k];
                    end
                endcase
                push_load(k, t, pick_pos(), pick_pos(), pick_pos());
            end
        end
    endtask

    initial
    begin
        logic [TIME_W-1:0] t;
        int unsigned n;
        errors        = 0;
        idle_cycles   = 0;
        live_count    = 0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_t[i] = '0; tbl_x[i] = '0; tbl_y[i] = '0; tbl_z[i] = '0;
            plan_t[i] = '0; plan_written[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        write_key_count(0);
        push_query(32'h0001_0000);
        push_query(32'hffff_ffff);

        // eight keys with extreme positions and a zero-length interval
        push_load(0, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
        push_load(1, 32'h0002_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        push_load(2, 32'h0002_0000, 32'h1234_5678, 32'h0, 32'h8000_0000);
        push_load(3, 32'h0003_8000, 32'hffff_0000, 32'h0001_0000, 32'h7fff_ffff);
        push_load(4, 32'h0010_0000, 32'h0, 32'hffff_ffff, 32'h0);
        push_load(5, 32'h0010_0001, 32'h7fff_ffff, 32'h0, 32'h8000_0000);
        push_load(6, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h5555_5555);
        push_load(7, 32'hffff_fffe, 32'h0, 32'h8000_0000, 32'haaaa_aaaa);
        write_key_count(8);
        push_query(32'h0000_0000);
        push_query(32'h0001_0000);
        push_query(32'h0001_8000);
        push_query(32'h0002_0000);
        push_query(32'h0002_0001);
        push_query(32'h0010_0001);
        push_query(32'h7fff_ffff);
        push_query(32'hffff_fffe);
        push_query(32'hffff_ffff);
        write_key_count(1);
        push_query(32'h0000_0000);
        push_query(32'hffff_ffff);

        // fill the whole table in nondecreasing time order
        write_key_count(0);
        t = 32'h0000_1000;
        for (int k = 0; k < DEPTH; k++)
        begin
            push_load(k, t, pick_pos(), pick_pos(), pick_pos());
            t = t + $urandom_range(0, 32'h0300_0000);
        end
        write_key_count(64);
        random_phase(64, 60);
        write_key_count(2);
        random_phase(2, 60);
        write_key_count(5);
        random_phase(5, 60);
        write_key_count(0);
        random_phase(0, 20);
        write_key_count(64);
        random_phase(64, 60);
        write_key_count(3);
        random_phase(3, 50);
        write_key_count(33);
        random_phase(33, 70);
        for (int p = 0; p < 3; p++)
        begin
            n = $urandom_range(1, 64);
            write_key_count(n);
            random_phase(n, 50);
        end

        wait_idle();
        if (errors == 0 && expected_positions.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
